### hw/rtl/hhd_pkg.sv
// shared types, constants and helpers for the hci h4 uart deframer
`default_nettype none

package hhd_pkg;

   localparam int LENGTH_WIDTH = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] TYPE_CMD = 8'h01;
   localparam logic [7:0] TYPE_ACL = 8'h02;
   localparam logic [7:0] TYPE_EVT = 8'h04;

   localparam logic [1:0] KIND_CMD = 2'd0;
   localparam logic [1:0] KIND_ACL = 2'd1;
   localparam logic [1:0] KIND_EVT = 2'd2;

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // what one queued run turns into on the result side
   localparam logic [1:0] MODE_REJECT  = 2'd0;
   localparam logic [1:0] MODE_HEADER  = 2'd1;
   localparam logic [1:0] MODE_PAYLOAD = 2'd2;

   typedef struct packed {
      logic [1:0]      mode;
      logic [1:0]      kind;
      logic [2:0]      hdr_len;
      logic            last;
      logic [3:0][7:0] bytes;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] kind_to_byte(input logic [1:0] kind);
      logic [7:0] b;
      unique case (kind)
         KIND_CMD: b = TYPE_CMD;
         KIND_ACL: b = TYPE_ACL;
         KIND_EVT: b = TYPE_EVT;
         default:  b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hhd_if.sv
// valid/ready channel interfaces for received bytes and deframed results
`default_nettype none

interface hhd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hhd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] frame_kind;
   logic       frame_first;
   logic       frame_last;
   logic       rejected;
   logic       run_last;

   modport source (output valid, output out_byte, output frame_kind, output frame_first,
                   output frame_last, output rejected, output run_last, input ready);
   modport sink   (input valid, input out_byte, input frame_kind, input frame_first,
                   input frame_last, input rejected, input run_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/hci_h4_uart_deframer_top.sv
// hci h4 uart deframer: received uart bytes in, framed h4 bytes out
//
// req_chan carries one received byte per transaction. bytes other than the
// command, acl and event type codes are dropped while no frame is open.
// after the header is complete the type byte and the header bytes leave as
// one run of results; each payload byte then leaves on its own. a payload
// length above csr max_payload gives a single rejected result instead.
// rsp_chan carries the results; run_last marks the last one caused by a byte.
// csr_wr_en/csr_wr_data write max_payload (1024 after reset); the user must
// write it only while idle, as the block itself does not enforce this.
// throughput: one byte per cycle in while the run queue is not full; one
// result per cycle out from the emitter while rsp_chan.ready is high; an
// acl header run has five results. a byte's run is written to the run queue
// at the accepting edge; the emitter output register is loaded from it later.
// a four-entry run queue sits between parser and emitter; when the receiver
// stalls the queue fills and req_chan.ready drops until it drains.
// reset clears the parser, the queue and the output valid at once.
`default_nettype none

module hci_h4_uart_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   hhd_req_if.sink          req_chan,
   hhd_rsp_if.source        rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import hhd_pkg::*;

   logic [15:0]      max_payload_ff;
   logic [15:0]      max_payload_in;
   logic             push;
   logic             pop;
   run_type          push_run;
   run_type          head;
   queue_status_type q_status;

   assign max_payload_in = csr_wr_en ? csr_wr_data : max_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   hhd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .max_payload (max_payload_ff),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_byte     (req_chan.rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_run    (push_run)
   );

   hhd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   hhd_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_byte    (rsp_chan.out_byte),
      .frame_kind  (rsp_chan.frame_kind),
      .frame_first (rsp_chan.frame_first),
      .frame_last  (rsp_chan.frame_last),
      .rejected    (rsp_chan.rejected),
      .run_last    (rsp_chan.run_last)
   );

endmodule

`default_nettype wire

### hw/rtl/hhd_parser.sv
// front end: tracks the h4 framing state and queues one run per result-causing byte
`default_nettype none

module hhd_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [15:0]              max_payload,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [7:0]               in_byte,
   input  wire hhd_pkg::queue_status_type q_status,
   output logic                          push,
   output hhd_pkg::run_type              push_run
);
   import hhd_pkg::*;

   localparam logic [1:0] PH_TYPE = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_PAY  = 2'd2;

   localparam logic [15:0] LEN_MAX = 16'((32'd1 << LENGTH_WIDTH) - 32'd1);

   logic [1:0]              phase_ff, phase_in;
   logic [1:0]              ftype_ff, ftype_in;
   logic [3:0][7:0]         hdr_ff, hdr_in;
   logic [2:0]              hcnt_ff, hcnt_in;
   logic [2:0]              hneed_ff, hneed_in;
   logic [LENGTH_WIDTH-1:0] pneed_ff, pneed_in;
   logic [LENGTH_WIDTH-1:0] pcnt_ff, pcnt_in;

   logic                    accept;
   logic [3:0][7:0]         hdr_next;
   logic [2:0]              hcnt_inc;
   logic [LENGTH_WIDTH-1:0] pcnt_inc;
   logic [15:0]             len;
   logic [15:0]             limit;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign hcnt_inc = hcnt_ff + 3'd1;
   assign pcnt_inc = pcnt_ff + 1'b1;
   assign limit    = (max_payload < LEN_MAX) ? max_payload : LEN_MAX;

   always_comb begin
      hdr_next = hdr_ff;
      hdr_next[hcnt_ff[1:0]] = in_byte;
   end

   // length field, with the byte arriving now already in place
   always_comb begin
      unique case (ftype_ff)
         KIND_EVT: len = {8'h00, hdr_next[1]};
         KIND_ACL: len = {hdr_next[3], hdr_next[2]};
         default:  len = {8'h00, hdr_next[2]};
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      ftype_in = ftype_ff;
      hdr_in   = hdr_ff;
      hcnt_in  = hcnt_ff;
      hneed_in = hneed_ff;
      pneed_in = pneed_ff;
      pcnt_in  = pcnt_ff;
      push     = 1'b0;
      push_run.mode    = MODE_HEADER;
      push_run.kind    = ftype_ff;
      push_run.hdr_len = hneed_ff;
      push_run.last    = 1'b0;
      push_run.bytes   = hdr_next;

      if (accept) begin
         unique case (phase_ff)
            PH_TYPE: begin
               priority if (in_byte == TYPE_CMD) begin
                  ftype_in = KIND_CMD;
                  hneed_in = 3'd3;
                  hcnt_in  = 3'd0;
                  phase_in = PH_HDR;
               end else if (in_byte == TYPE_ACL) begin
                  ftype_in = KIND_ACL;
                  hneed_in = 3'd4;
                  hcnt_in  = 3'd0;
                  phase_in = PH_HDR;
               end else if (in_byte == TYPE_EVT) begin
                  ftype_in = KIND_EVT;
                  hneed_in = 3'd2;
                  hcnt_in  = 3'd0;
                  phase_in = PH_HDR;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
            PH_HDR: begin
               hdr_in  = hdr_next;
               hcnt_in = hcnt_inc;
               if (hcnt_inc >= hneed_ff) begin
                  push = 1'b1;
                  if (len > limit) begin
                     push_run.mode = MODE_REJECT;
                     phase_in = PH_TYPE;
                     ftype_in = KIND_CMD;
                     hcnt_in  = 3'd0;
                     hneed_in = 3'd0;
                     pneed_in = '0;
                     pcnt_in  = '0;
                  end else if (len == 16'd0) begin
                     push_run.last = 1'b1;
                     phase_in = PH_TYPE;
                     ftype_in = KIND_CMD;
                     hcnt_in  = 3'd0;
                     hneed_in = 3'd0;
                     pneed_in = '0;
                     pcnt_in  = '0;
                  end else begin
                     pneed_in = len[LENGTH_WIDTH-1:0];
                     pcnt_in  = '0;
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               push             = 1'b1;
               push_run.mode    = MODE_PAYLOAD;
               push_run.bytes   = {24'h000000, in_byte};
               push_run.last    = (pcnt_inc == pneed_ff);
               pcnt_in          = pcnt_inc;
               if (pcnt_inc == pneed_ff) begin
                  phase_in = PH_TYPE;
                  ftype_in = KIND_CMD;
                  hcnt_in  = 3'd0;
                  hneed_in = 3'd0;
                  pneed_in = '0;
                  pcnt_in  = '0;
               end
            end
            default: begin
               phase_in = PH_TYPE;
               ftype_in = KIND_CMD;
               hcnt_in  = 3'd0;
               hneed_in = 3'd0;
               pneed_in = '0;
               pcnt_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         ftype_ff <= KIND_CMD;
         hcnt_ff  <= 3'd0;
         hneed_ff <= 3'd0;
         pneed_ff <= '0;
         pcnt_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         ftype_ff <= ftype_in;
         hcnt_ff  <= hcnt_in;
         hneed_ff <= hneed_in;
         pneed_ff <= pneed_in;
         pcnt_ff  <= pcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

`default_nettype wire

### hw/rtl/hhd_queue.sv
// small fifo of pending runs between the parser and the emitter
`default_nettype none

module hhd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire hhd_pkg::run_type     push_run,
   input  wire logic                 pop,
   output hhd_pkg::run_type          head,
   output hhd_pkg::queue_status_type status
);
   import hhd_pkg::*;

   run_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/hhd_emitter.sv
// back end: unrolls each queued run into result transactions, one per cycle while the output is not stalled
`default_nettype none

module hhd_emitter (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hhd_pkg::run_type         head,
   input  wire hhd_pkg::queue_status_type q_status,
   output logic                          pop,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [7:0]                    out_byte,
   output logic [1:0]                    frame_kind,
   output logic                          frame_first,
   output logic                          frame_last,
   output logic                          rejected,
   output logic                          run_last
);
   import hhd_pkg::*;

   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] kind_ff, kind_in;
   logic       first_ff, first_in;
   logic       last_ff, last_in;
   logic       rej_ff, rej_in;
   logic       rlast_ff, rlast_in;

   logic       load;
   logic       emit;
   logic       done;
   logic [1:0] sel;

   assign load = !valid_ff || out_ready;
   assign sel  = 2'(idx_ff - 3'd1);

   always_comb begin
      emit     = 1'b0;
      done     = 1'b0;
      byte_in  = byte_ff;
      kind_in  = head.kind;
      first_in = 1'b0;
      last_in  = 1'b0;
      rej_in   = 1'b0;
      rlast_in = 1'b0;
      unique case (head.mode)
         MODE_REJECT: begin
            emit     = 1'b1;
            done     = 1'b1;
            byte_in  = 8'h00;
            rej_in   = 1'b1;
            rlast_in = 1'b1;
         end
         MODE_PAYLOAD: begin
            emit     = 1'b1;
            done     = 1'b1;
            byte_in  = head.bytes[0];
            last_in  = head.last;
            rlast_in = 1'b1;
         end
         MODE_HEADER: begin
            emit = 1'b1;
            if (idx_ff == 3'd0) begin
               byte_in  = kind_to_byte(head.kind);
               first_in = 1'b1;
            end else begin
               byte_in  = head.bytes[sel];
               done     = (idx_ff == head.hdr_len);
               last_in  = done && head.last;
               rlast_in = done;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b0;
         if (!q_status.empty) begin
            valid_in = emit;
            pop      = done;
            idx_in   = done ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_in;
         kind_ff  <= kind_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         rej_ff   <= rej_in;
         rlast_ff <= rlast_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign frame_kind  = kind_ff;
   assign frame_first = first_ff;
   assign frame_last  = last_ff;
   assign rejected    = rej_ff;
   assign run_last    = rlast_ff;

endmodule

`default_nettype wire

### hw/rtl/hhd_checker.sv
// port-level assertions for the deframer result channel, bound to the top level
`default_nettype none

module hhd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_frame_first,
   input wire logic       rsp_frame_last,
   input wire logic       rsp_rejected,
   input wire logic       rsp_run_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_run_last))
      else $error("result changed while stalled");

   // a rejected frame shows as one bare result
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_out_byte == 8'h00 && !rsp_frame_first
                                    && !rsp_frame_last && rsp_run_last)
      else $error("malformed rejected result");

   // the type byte is always followed by header bytes of the same run
   a_first_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_first |-> !rsp_run_last)
      else $error("type byte closes its run");

   // a frame can only end on the last result of a byte
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_run_last)
      else $error("frame end inside a run");

endmodule

bind hci_h4_uart_deframer_top hhd_checker u_hhd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_frame_first (rsp_chan.frame_first),
   .rsp_frame_last  (rsp_chan.frame_last),
   .rsp_rejected    (rsp_chan.rejected),
   .rsp_run_last    (rsp_chan.run_last)
);

`default_nettype wire
